FILE: rtl/eased_value_tween_macros.svh
// Assertion macros for the eased value tween block.
`ifndef EASED_VALUE_TWEEN_MACROS_SVH
`define EASED_VALUE_TWEEN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EVT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("evt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define EVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("evt assertion failed");

`endif

FILE: rtl/evt_pkg.sv
// Shared constants and types for the eased value tween block.
`timescale 1ns / 1ps

package evt_pkg;

  localparam int VAL_W  = 16;          // value and tick counter width
  localparam int MLR_W  = 17;          // serial multiplier operand (bit per cycle)
  localparam int MCD_W  = 18;          // parallel multiplicand
  localparam int ACC_W  = MLR_W + MCD_W;
  localparam int FRAC_W = 16;          // Q0.16 / Q2.16 fraction bits
  localparam int CNT_W  = 5;           // step counter, up to MLR_W steps

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_SET      = 3'd1;
  localparam logic [2:0] OP_RETARGET = 3'd2;
  localparam logic [2:0] OP_RESTART  = 3'd3;
  localparam logic [2:0] OP_SOFT     = 3'd4;

  localparam logic [2:0] CRV_LINEAR    = 3'd0;
  localparam logic [2:0] CRV_IN_QUAD   = 3'd1;
  localparam logic [2:0] CRV_OUT_QUAD  = 3'd2;
  localparam logic [2:0] CRV_IO_QUAD   = 3'd3;
  localparam logic [2:0] CRV_IN_CUBIC  = 3'd4;
  localparam logic [2:0] CRV_OUT_CUBIC = 3'd5;
  localparam logic [2:0] CRV_IO_CUBIC  = 3'd6;
  localparam logic [2:0] CRV_SMOOTH    = 3'd7;

  // multiply phases
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_VALUE  = 2'd2;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [MLR_W-1:0] prog_t;
  typedef logic [MCD_W-1:0] mcd_t;

endpackage

FILE: rtl/eased_value_tween.sv
// Eased value tween: command-driven animated 16-bit value generator.
//
// Input channel in_*: one request per command. in_tuser carries the opcode
// (tick, set hard, retarget, hard restart, soft restart); in_tdata carries
// new_value and duration. Output channel out_*: exactly one result per
// request, the present value and the running flag after the command.
// cfg_* writes the easing curve select; write it only while the block is idle.
//
// Set commands, unknown opcodes and ticks that do not interpolate answer
// straight from the idle state. An interpolating tick runs a bit-serial
// divide for t, one prep step, then 1 to 3 bit-serial multiplies of 17
// multiplier bits plus a step state each: one for linear, two for quad
// curves, three for cubic curves and smoothstep. One request is
// in flight at a time; in_tready is high only while the sequencer is idle
// and the result register is free or being drained.
// A stalled receiver holds the result in the output register; no new request
// is taken until it drains. Reset clears the curve select, the start, end and
// present values and counters; the block is left idle with no result pending.
`timescale 1ns / 1ps
`include "eased_value_tween_macros.svh"

module eased_value_tween import evt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] new_value, [31:16] duration
  input  logic [2:0]  in_tuser,   // [2:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] current_value, [16] running, [23:17] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // [2:0] curve_select, [7:3] unused
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_NEXT = 3'd4;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(VAL_W - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MLR_W - 1);

  // Q3.16 constants
  localparam logic [18:0] Q1 = 19'h10000;
  localparam logic [18:0] Q2 = 19'h20000;
  localparam logic [18:0] Q3 = 19'h30000;
  localparam logic [18:0] Q4 = 19'h40000;

  logic [2:0]       stage_r, stage_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       ph_r, ph_nxt;
  logic [2:0]       curve_r, curve_nxt;
  val_t             start_r, start_nxt;
  val_t             end_r, end_nxt;
  val_t             pres_r, pres_nxt;
  val_t             tc_r, tc_nxt;
  val_t             tl_r, tl_nxt;
  logic             busy_r, busy_nxt;
  val_t             rem_r, rem_nxt;
  val_t             quo_r, quo_nxt;
  prog_t            mlr_r, mlr_nxt;
  mcd_t             mcd_r, mcd_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  val_t             mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic             out_valid_r, out_valid_nxt;
  val_t             out_val_r, out_val_nxt;
  logic             out_run_r, out_run_nxt;

  logic             in_acc;
  logic [2:0]       op;
  val_t             nv;
  val_t             dur;

  assign op        = in_tuser;
  assign nv        = in_tdata[15:0];
  assign dur       = in_tdata[31:16];
  assign in_tready = (stage_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_run_r, out_val_r};

  always_comb begin
    logic [VAL_W:0]   r2;
    logic [VAL_W:0]   rdiff;
    logic             ge;
    logic [MCD_W:0]   sum;
    logic             t_lo;
    prog_t            t17;
    prog_t            v1;
    prog_t            v2;
    logic [18:0]      q;
    prog_t            p;
    logic [VAL_W:0]   diff;
    val_t             m;
    logic             res_wr;
    logic             go_final;
    logic [2:0]       sel;

    stage_nxt     = stage_r;
    cnt_nxt       = cnt_r;
    ph_nxt        = ph_r;
    curve_nxt     = curve_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    pres_nxt      = pres_r;
    tc_nxt        = tc_r;
    tl_nxt        = tl_r;
    busy_nxt      = busy_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    mlr_nxt       = mlr_r;
    mcd_nxt       = mcd_r;
    acc_nxt       = acc_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_val_nxt   = out_val_r;
    out_run_nxt   = out_run_r;
    res_wr        = 1'b0;
    go_final      = 1'b0;
    p             = '0;
    sel           = curve_r;

    // curve operands derived from t
    t_lo = !quo_r[VAL_W-1];
    t17  = {1'b0, quo_r};
    v1   = MLR_W'(Q1 - {3'd0, quo_r});
    v2   = MLR_W'(Q2 - {2'd0, quo_r, 1'b0});
    q    = acc_r[ACC_W-1:FRAC_W];

    r2    = {rem_r, 1'b0};
    rdiff = r2 - {1'b0, tl_r};
    ge    = (r2 >= {1'b0, tl_r});
    sum   = {1'b0, acc_r[ACC_W-1:MLR_W]} + (mlr_r[0] ? {1'b0, mcd_r} : '0);
    diff  = {end_r[VAL_W-1], end_r} - {start_r[VAL_W-1], start_r};
    m     = acc_r[FRAC_W+VAL_W-1:FRAC_W];

    if (cfg_valid && cfg_ready) begin
      curve_nxt = cfg_data[2:0];
    end

    case (stage_r)
      S_IDLE: begin
        if (in_acc) begin
          res_wr = 1'b1;
          case (op)
            OP_TICK: begin
              if (busy_r && (tc_r < tl_r)) begin
                res_wr    = 1'b0;
                stage_nxt = S_DIV;
                rem_nxt   = tc_r;
                quo_nxt   = '0;
                cnt_nxt   = '0;
              end else if (busy_r) begin
                pres_nxt = end_r;
                busy_nxt = 1'b0;
              end
            end
            OP_SET: begin
              pres_nxt  = nv;
              start_nxt = nv;
              end_nxt   = nv;
              tc_nxt    = '0;
              busy_nxt  = 1'b0;
            end
            OP_RETARGET: begin
              end_nxt = nv;
              tl_nxt  = dur;
              tc_nxt  = '0;
              if (!busy_r) begin
                start_nxt = pres_r;
                busy_nxt  = 1'b1;
              end
            end
            OP_RESTART: begin
              start_nxt = pres_r;
              end_nxt   = nv;
              tl_nxt    = dur;
              tc_nxt    = '0;
              busy_nxt  = 1'b1;
            end
            OP_SOFT: begin
              tl_nxt    = (tl_r > tc_r) ? (tl_r - tc_r) : '0;
              start_nxt = pres_r;
              end_nxt   = nv;
              tc_nxt    = '0;
              busy_nxt  = 1'b1;
            end
            default: ;
          endcase
        end
      end

      // restoring divide: t = (tc << 16) / tl, one quotient bit per cycle
      S_DIV: begin
        rem_nxt = ge ? rdiff[VAL_W-1:0] : r2[VAL_W-1:0];
        quo_nxt = {quo_r[VAL_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          stage_nxt = S_PREP;
        end
      end

      S_PREP: begin
        neg_nxt   = diff[VAL_W];
        mag_nxt   = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
        acc_nxt   = '0;
        cnt_nxt   = '0;
        stage_nxt = S_MUL;
        ph_nxt    = PH_FIRST;
        mlr_nxt   = t17;
        mcd_nxt   = {1'b0, t17};
        case (sel)
          CRV_LINEAR: begin
            ph_nxt  = PH_VALUE;
            mcd_nxt = {2'd0, diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0]};
          end
          CRV_OUT_QUAD: mcd_nxt = MCD_W'(Q2 - {3'd0, quo_r});
          CRV_IO_QUAD: begin
            mcd_nxt = t_lo ? {1'b0, quo_r, 1'b0} : MCD_W'(Q4 - {2'd0, quo_r, 1'b0});
          end
          CRV_OUT_CUBIC: begin
            mlr_nxt = v1;
            mcd_nxt = {1'b0, v1};
          end
          CRV_IO_CUBIC: begin
            if (!t_lo) begin
              mlr_nxt = v2;
              mcd_nxt = {1'b0, v2};
            end
          end
          default: ;
        endcase
      end

      // shift-add multiply, one multiplier bit per cycle
      S_MUL: begin
        acc_nxt = {sum, acc_r[MLR_W-1:1]};
        mlr_nxt = mlr_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          stage_nxt = S_NEXT;
        end
      end

      S_NEXT: begin
        acc_nxt = '0;
        cnt_nxt = '0;
        case (ph_r)
          PH_FIRST: begin
            case (sel)
              CRV_IN_QUAD, CRV_OUT_QUAD: begin
                p        = q[MLR_W-1:0];
                go_final = 1'b1;
              end
              CRV_IO_QUAD: begin
                p        = t_lo ? q[MLR_W-1:0] : MLR_W'(q - Q1);
                go_final = 1'b1;
              end
              default: begin
                // cubic curves and smoothstep take a second product
                stage_nxt = S_MUL;
                ph_nxt    = PH_SECOND;
                mlr_nxt   = q[MLR_W-1:0];
                mcd_nxt   = {1'b0, t17};
                if (sel == CRV_OUT_CUBIC) begin
                  mcd_nxt = {1'b0, v1};
                end else if (sel == CRV_IO_CUBIC && !t_lo) begin
                  mcd_nxt = {1'b0, v2};
                end else if (sel == CRV_SMOOTH) begin
                  mcd_nxt = MCD_W'(Q3 - {2'd0, quo_r, 1'b0});
                end
              end
            endcase
          end
          PH_SECOND: begin
            go_final = 1'b1;
            case (sel)
              CRV_OUT_CUBIC: p = MLR_W'(Q1 - q);
              CRV_IO_CUBIC: begin
                p = t_lo ? {q[MLR_W-3:0], 2'b00} : MLR_W'(Q1 - (q >> 1));
              end
              default: p = q[MLR_W-1:0];
            endcase
          end
          default: begin
            pres_nxt  = start_r + (neg_r ? VAL_W'(-m) : m);
            tc_nxt    = tc_r + 1'b1;
            res_wr    = 1'b1;
            stage_nxt = S_IDLE;
          end
        endcase
        if (go_final) begin
          stage_nxt = S_MUL;
          ph_nxt    = PH_VALUE;
          mlr_nxt   = p;
          mcd_nxt   = {2'd0, mag_r};
        end
      end

      default: stage_nxt = S_IDLE;
    endcase

    if (res_wr) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = pres_nxt;
      out_run_nxt   = busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= S_IDLE;
      cnt_r       <= '0;
      ph_r        <= PH_FIRST;
      curve_r     <= CRV_LINEAR;
      start_r     <= '0;
      end_r       <= '0;
      pres_r      <= '0;
      tc_r        <= '0;
      tl_r        <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stage_r     <= stage_nxt;
      cnt_r       <= cnt_nxt;
      ph_r        <= ph_nxt;
      curve_r     <= curve_nxt;
      start_r     <= start_nxt;
      end_r       <= end_nxt;
      pres_r      <= pres_nxt;
      tc_r        <= tc_nxt;
      tl_r        <= tl_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    mlr_r     <= mlr_nxt;
    mcd_r     <= mcd_nxt;
    acc_r     <= acc_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    out_val_r <= out_val_nxt;
    out_run_r <= out_run_nxt;
  end

  // non-tick requests always answer on the next cycle
  `EVT_ASSERT_NEXT(a_set_answers, clk, rst_n, in_tvalid && in_tready && in_tuser != OP_TICK, out_tvalid)
  // interpolation only runs on a live animation with ticks left
  `EVT_ASSERT_NOW(a_div_busy, clk, rst_n, stage_r == S_DIV, busy_r && (tc_r < tl_r))
  // multiplier step counter stays within the operand width
  `EVT_ASSERT_NOW(a_mul_cnt, clk, rst_n, stage_r == S_MUL, cnt_r <= MUL_LAST)
  // a compute pass never starts with a result still pending
  `EVT_ASSERT_NOW(a_prep_free, clk, rst_n, stage_r == S_PREP, !out_valid_r)

endmodule

FILE: dv/eased_value_tween_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for eased_value_tween: directed commands, then random tween sequences.

module eased_value_tween_tb;
  import evt_pkg::*;

  // opcodes the block does not decode
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int DRAIN_CYCLES  = 100;
  localparam int PHASES        = 16;
  localparam int MOVES_PER_PH  = 50;
  // ~1100 requests, with long gaps and stalls
  localparam int LIMIT_CYCLES  = 2_000_000;
  localparam logic [63:0] Q_UNIT = 64'd65536;

  typedef struct {
    val_t value;
    logic running;
  } tween_result_t;

  typedef struct packed {
    logic [2:0] op;
    val_t       nv;
    val_t       dur;
    logic       known;
    val_t       kv;
    logic       kr;
  } directed_row_t;

  localparam int N_DIRECTED = 26;

  // known = 1: expected value/running typed in; otherwise predicted
  directed_row_t directed [N_DIRECTED] = '{
    '{OP_TICK,     16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0},  // idle tick after reset
    '{OP_RSVD5,    16'h1234, 16'hffff, 1'b1, 16'h0000, 1'b0},
    '{OP_SET,      16'h8000, 16'h0000, 1'b1, 16'h8000, 1'b0},
    '{OP_RESTART,  16'h7fff, 16'h0000, 1'b1, 16'h8000, 1'b1},  // zero duration
    '{OP_TICK,     16'h0000, 16'h0000, 1'b1, 16'h7fff, 1'b0},  // snaps to end
    '{OP_SET,      16'h7fff, 16'hffff, 1'b1, 16'h7fff, 1'b0},
    '{OP_RETARGET, 16'h8000, 16'hffff, 1'b1, 16'h7fff, 1'b1},
    '{OP_TICK,     16'h0000, 16'h0000, 1'b1, 16'h7fff, 1'b1},  // t = 0
    '{OP_TICK,     16'hffff, 16'hffff, 1'b0, 16'h0000, 1'b0},
    '{OP_SOFT,     16'h0064, 16'h1234, 1'b0, 16'h0000, 1'b0},
    '{OP_TICK,     16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{OP_RETARGET, 16'h0000, 16'h0004, 1'b0, 16'h0000, 1'b0},  // running: keeps start
    '{OP_TICK,     16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{OP_TICK,     16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{OP_TICK,     16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{OP_TICK,     16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{OP_TICK,     16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0},  // count hit limit
    '{OP_SOFT,     16'h1000, 16'hffff, 1'b1, 16'h0000, 1'b1},  // no ticks remain
    '{OP_TICK,     16'h0000, 16'h0000, 1'b1, 16'h1000, 1'b0},
    '{OP_RSVD6,    16'hffff, 16'hffff, 1'b1, 16'h1000, 1'b0},
    '{OP_RSVD7,    16'h5555, 16'haaaa, 1'b1, 16'h1000, 1'b0},
    '{OP_TICK,     16'h0000, 16'h0000, 1'b1, 16'h1000, 1'b0},
    '{OP_RESTART,  16'h8000, 16'h0003, 1'b1, 16'h1000, 1'b1},
    '{OP_TICK,     16'h0000, 16'h0000, 1'b1, 16'h1000, 1'b1},
    '{OP_TICK,     16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{OP_SET,      16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  // predictor state
  logic [2:0]         m_curve;
  logic signed [15:0] m_start;
  logic signed [15:0] m_end;
  logic signed [15:0] m_present;
  logic [15:0]        m_count;
  logic [15:0]        m_limit;
  logic               m_busy;

  tween_result_t pending_results[$];
  tween_result_t want;
  int  mismatches;
  int  phase_moves;
  int  cycles;
  bit  sender_calm;
  bit  stall_calm;

  eased_value_tween dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 16;
  endfunction

  // progress p in Q2.16 for phase t in Q0.16
  function automatic logic [63:0] ease_progress(input logic [2:0] crv, input logic [63:0] t);
    logic [63:0] v;
    case (crv)
      CRV_LINEAR:   return t;
      CRV_IN_QUAD:  return qmul(t, t);
      CRV_OUT_QUAD: return qmul(t, 2 * Q_UNIT - t);
      CRV_IO_QUAD: begin
        if (t < Q_UNIT / 2) return qmul(2 * t, t);
        return qmul(4 * Q_UNIT - 2 * t, t) - Q_UNIT;
      end
      CRV_IN_CUBIC: return qmul(qmul(t, t), t);
      CRV_OUT_CUBIC: begin
        v = Q_UNIT - t;
        return Q_UNIT - qmul(qmul(v, v), v);
      end
      CRV_IO_CUBIC: begin
        if (t < Q_UNIT / 2) return 4 * qmul(qmul(t, t), t);
        v = 2 * Q_UNIT - 2 * t;
        return Q_UNIT - (qmul(qmul(v, v), v) >> 1);
      end
      CRV_SMOOTH:   return qmul(qmul(t, t), 3 * Q_UNIT - 2 * t);
      default:      return t;
    endcase
  endfunction

  // applies one command to the predictor; moved flags commands that change anything
  task automatic tween_step(input logic [2:0] op, input val_t nv, input val_t dur,
                            output tween_result_t res, output bit moved);
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] mag;
    longint      diff;
    longint      sum;
    moved = 1'b1;
    case (op)
      OP_TICK: begin
        moved = m_busy;
        if (m_busy) begin
          if (m_count >= m_limit || m_limit == 16'd0) begin
            m_present = m_end;
            m_busy    = 1'b0;
          end else begin
            t    = {32'd0, m_count, 16'd0} / {48'd0, m_limit};
            p    = ease_progress(m_curve, t);
            diff = longint'(m_end) - longint'(m_start);
            mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
            mag  = (mag * p) >> 16;
            sum  = longint'(m_start) + ((diff < 0) ? -longint'(mag) : longint'(mag));
            m_present = sum[15:0];
            m_count   = m_count + 16'd1;
          end
        end
      end
      OP_SET: begin
        m_present = nv;
        m_start   = nv;
        m_end     = nv;
        m_count   = 16'd0;
        m_busy    = 1'b0;
      end
      OP_RETARGET: begin
        m_end   = nv;
        m_limit = dur;
        m_count = 16'd0;
        if (!m_busy) begin
          m_start = m_present;
          m_busy  = 1'b1;
        end
      end
      OP_RESTART: begin
        m_start = m_present;
        m_end   = nv;
        m_limit = dur;
        m_count = 16'd0;
        m_busy  = 1'b1;
      end
      OP_SOFT: begin
        m_limit = (m_limit > m_count) ? m_limit - m_count : 16'd0;
        m_start = m_present;
        m_end   = nv;
        m_count = 16'd0;
        m_busy  = 1'b1;
      end
      default: moved = 1'b0;
    endcase
    res.value   = m_present;
    res.running = m_busy;
  endtask

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic val_t pick_value();
    case ($urandom_range(0, 19))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return val_t'($urandom);
    endcase
  endfunction

  function automatic val_t pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return val_t'($urandom_range(0, 10));
    if (r < 85) return val_t'($urandom_range(11, 200));
    return val_t'($urandom);
  endfunction

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_cmd(input logic [2:0] op, input val_t nv, input val_t dur,
                          input logic known, input val_t kv, input logic kr);
    int            gap;
    tween_result_t res;
    bit            moved;
    gap = pick_gap(sender_calm);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= {dur, nv};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tween_step(op, nv, dur, res, moved);
    if (known) begin
      res.value   = kv;
      res.running = kr;
    end
    pending_results.push_back(res);
    if (moved) phase_moves++;
    @(negedge clk);
  endtask

  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_curve(input logic [2:0] crv);
    logic [4:0] junk;
    junk = 5'($urandom);
    settle_idle();
    cfg_data  <= {junk, crv};
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    m_curve = crv;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly a start command followed by ticks (enough to finish a short one), with some noise
  task automatic run_tween_sequence();
    int         r;
    int         n;
    int         k;
    logic [2:0] op;
    val_t       d;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      case ($urandom_range(0, 2))
        0:       op = OP_RETARGET;
        1:       op = OP_RESTART;
        default: op = OP_SOFT;
      endcase
      d = pick_duration();
      send_cmd(op, pick_value(), d, 1'b0, '0, 1'b0);
      if (op != OP_SOFT && d <= 16'd10) n = int'(d) + 1 + $urandom_range(0, 2);
      else n = $urandom_range(1, 12);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 29) == 0) begin
          case ($urandom_range(0, 2))
            0:       op = OP_RETARGET;
            1:       op = OP_SOFT;
            default: op = OP_SET;
          endcase
          send_cmd(op, pick_value(), pick_duration(), 1'b0, '0, 1'b0);
        end else begin
          send_cmd(OP_TICK, val_t'($urandom), val_t'($urandom), 1'b0, '0, 1'b0);
        end
      end
    end else if (r < 80) begin
      send_cmd(OP_SET, pick_value(), val_t'($urandom), 1'b0, '0, 1'b0);
    end else if (r < 88) begin
      op = 3'($urandom_range(int'(OP_RSVD5), int'(OP_RSVD7)));
      send_cmd(op, val_t'($urandom), val_t'($urandom), 1'b0, '0, 1'b0);
    end else begin
      send_cmd(3'($urandom), val_t'($urandom), val_t'($urandom), 1'b0, '0, 1'b0);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value=%0d running=%0b",
                   $signed(out_tdata[15:0]), out_tdata[16]);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[15:0] !== want.value || out_tdata[16] !== want.running) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp value=%0d running=%0b, got value=%0d running=%0b",
                     $signed(want.value), want.running,
                     $signed(out_tdata[15:0]), out_tdata[16]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("eased_value_tween_tb: errors");
      $finish;
    end
  end

  // receiver backpressure, with calm stretches
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall_calm = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(4, 40)) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        stall = pick_gap(stall_calm);
        if (stall != 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
    end
  end

  initial begin
    int         i;
    int         ph;
    logic [2:0] crv;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_TICK;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    mismatches  = 0;
    cycles      = 0;
    phase_moves = 0;
    sender_calm = 1'b0;
    m_curve     = CRV_LINEAR;
    m_start     = '0;
    m_end       = '0;
    m_present   = '0;
    m_count     = '0;
    m_limit     = '0;
    m_busy      = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset curve is linear
    for (i = 0; i < N_DIRECTED; i++)
      send_cmd(directed[i].op, directed[i].nv, directed[i].dur,
               directed[i].known, directed[i].kv, directed[i].kr);

    // smoothstep first, then linear .. inout cubic, then random curves
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) crv = CRV_SMOOTH;
      else if (ph < 8) crv = 3'(ph - 1);
      else crv = 3'($urandom);
      write_curve(crv);
      phase_moves = 0;
      while (phase_moves < MOVES_PER_PH) begin
        sender_calm = ($urandom_range(0, 4) == 0);
        run_tween_sequence();
      end
    end

    settle_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("eased_value_tween_tb: clean");
    end else begin
      $display("eased_value_tween_tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/evt_pkg.sv
rtl/eased_value_tween.sv
dv/eased_value_tween_tb.sv
